// ===== hdl/magic_length_frame_deframer_core_assert.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MLFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlfd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MLFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlfd next-cycle check failed");

`endif

// ===== hdl/mlfd_pkg.sv =====
package mlfd_pkg;

   typedef enum logic [2:0] {
      ST_HEADER  = 3'd0,
      ST_PAYLOAD = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_ERROR   = 3'd3,
      ST_SKIP    = 3'd4
   } status_type;

   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REQUEST_KIND     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESPONSE_KIND    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EVENT_KIND       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH       = 3'd4;

   localparam logic [3:0] SYNC_BYTES = 4'd4;
   localparam logic [3:0] HDR_BYTES  = 4'd12;

   localparam logic [7:0] SYNC_PATTERN [4] = '{8'h41, 8'h51, 8'h4D, 8'h47};

endpackage

// ===== hdl/magic_length_frame_deframer_core.sv =====
// Byte-stream deframer for magic- and length-prefixed frames.
// req_ channel: one received byte per beat (req_rx_byte) plus req_chunk_end,
// which marks the last byte of a feed chunk and ends skipping after an error.
// rsp_ channel: exactly one result beat per request beat, in order: status,
// payload byte, frame kind, last flag and the running drop and error counts.
// csr_ port: single-cycle writes of version, the three kind codes and the
// maximum payload length; write only while no beat is in flight.
// Latency: a result is valid the cycle after its request beat is taken.
// Throughput: one byte per cycle; each byte is decoded by one pass of compare,
// shift and counter logic between the request port and the result register.
// A stalled receiver holds the result register; req_ready then drops until
// the held beat is taken, so nothing is lost or repeated.
// Reset (synchronous, active high) clears the hunt and frame state, both
// counters and the result valid, and loads the register defaults; the block
// takes a byte in the first cycle after reset.
module magic_length_frame_deframer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   input  logic                            req_chunk_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mlfd_pkg::status_type            rsp_status,
   output logic [7:0]                      rsp_data_byte,
   output logic [7:0]                      rsp_frame_kind,
   output logic                            rsp_frame_last,
   output logic [63:0]                     rsp_dropped_count,
   output logic [31:0]                     rsp_error_count,
   input  logic                            csr_wr_en,
   input  logic [mlfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wr_data
);
   import mlfd_pkg::*;

   logic [7:0]  expected_version_ff;
   logic [7:0]  request_kind_ff;
   logic [7:0]  response_kind_ff;
   logic [7:0]  event_kind_ff;
   logic [31:0] max_length_ff;

   logic [3:0]  header_count_ff, header_count_in;
   logic [63:0] header_fields_ff, header_fields_in;
   logic [31:0] payload_length_ff, payload_length_in;
   logic [31:0] payload_count_ff, payload_count_in;
   logic        skip_ff, skip_in;
   logic [63:0] dropped_total_ff, dropped_total_in;
   logic [31:0] error_total_ff, error_total_in;

   logic        rsp_valid_ff;
   status_type  status_ff, status_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  kind_ff, kind_in;
   logic        last_ff, last_in;

   logic        accept;
   logic [63:0] fields_shift;
   logic [31:0] count_inc;
   logic        hdr_bad;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign fields_shift = {header_fields_ff[55:0], req_rx_byte};
   assign count_inc    = payload_count_ff + 32'd1;

   // Header check on the shifted-in view, valid when the twelfth byte arrives.
   assign hdr_bad = (fields_shift[63:56] != expected_version_ff)
                 || !((fields_shift[55:48] == request_kind_ff)
                      || (fields_shift[55:48] == response_kind_ff)
                      || (fields_shift[55:48] == event_kind_ff))
                 || (fields_shift[47:40] != 8'd0)
                 || (fields_shift[39:32] != 8'd0)
                 || (fields_shift[31:0] > max_length_ff);

   always_comb begin
      header_count_in   = header_count_ff;
      header_fields_in  = header_fields_ff;
      payload_length_in = payload_length_ff;
      payload_count_in  = payload_count_ff;
      skip_in           = skip_ff;
      dropped_total_in  = dropped_total_ff;
      error_total_in    = error_total_ff;
      status_in         = ST_HEADER;
      data_in           = 8'd0;
      kind_in           = 8'd0;
      last_in           = 1'b0;

      if (skip_ff) begin
         status_in = ST_SKIP;
         if (req_chunk_end) begin
            skip_in = 1'b0;
         end
      end else if (header_count_ff < SYNC_BYTES) begin
         if (req_rx_byte == SYNC_PATTERN[header_count_ff[1:0]]) begin
            header_count_in = header_count_ff + 4'd1;
         end else begin
            // Drop the byte; a first sync byte restarts the hunt at one.
            dropped_total_in = dropped_total_ff + 64'd1;
            header_count_in  = (req_rx_byte == SYNC_PATTERN[0]) ? 4'd1 : 4'd0;
         end
      end else if (header_count_ff < HDR_BYTES) begin
         header_fields_in = fields_shift;
         header_count_in  = header_count_ff + 4'd1;
         if (header_count_ff == HDR_BYTES - 4'd1) begin
            if (hdr_bad) begin
               error_total_in    = error_total_ff + 32'd1;
               header_count_in   = 4'd0;
               header_fields_in  = 64'd0;
               payload_length_in = 32'd0;
               payload_count_in  = 32'd0;
               status_in         = ST_ERROR;
               skip_in           = !req_chunk_end;
            end else if (fields_shift[31:0] == 32'd0) begin
               status_in         = ST_EMPTY;
               kind_in           = fields_shift[55:48];
               last_in           = 1'b1;
               header_count_in   = 4'd0;
               header_fields_in  = 64'd0;
               payload_length_in = 32'd0;
               payload_count_in  = 32'd0;
            end else begin
               payload_length_in = fields_shift[31:0];
               payload_count_in  = 32'd0;
            end
         end
      end else begin
         payload_count_in = count_inc;
         status_in        = ST_PAYLOAD;
         data_in          = req_rx_byte;
         kind_in          = header_fields_ff[55:48];
         if (count_inc == payload_length_ff) begin
            last_in           = 1'b1;
            header_count_in   = 4'd0;
            header_fields_in  = 64'd0;
            payload_length_in = 32'd0;
            payload_count_in  = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= 8'd1;
         request_kind_ff     <= 8'd0;
         response_kind_ff    <= 8'd1;
         event_kind_ff       <= 8'd2;
         max_length_ff       <= 32'd65536;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EXPECTED_VERSION: expected_version_ff <= csr_wr_data[7:0];
            CSR_REQUEST_KIND:     request_kind_ff     <= csr_wr_data[7:0];
            CSR_RESPONSE_KIND:    response_kind_ff    <= csr_wr_data[7:0];
            CSR_EVENT_KIND:       event_kind_ff       <= csr_wr_data[7:0];
            CSR_MAX_LENGTH:       max_length_ff       <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff   <= 4'd0;
         header_fields_ff  <= 64'd0;
         payload_length_ff <= 32'd0;
         payload_count_ff  <= 32'd0;
         skip_ff           <= 1'b0;
         dropped_total_ff  <= 64'd0;
         error_total_ff    <= 32'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            header_count_ff   <= header_count_in;
            header_fields_ff  <= header_fields_in;
            payload_length_ff <= payload_length_in;
            payload_count_ff  <= payload_count_in;
            skip_ff           <= skip_in;
            dropped_total_ff  <= dropped_total_in;
            error_total_ff    <= error_total_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: load on accept, hold while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         kind_ff   <= kind_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_frame_kind    = kind_ff;
   assign rsp_frame_last    = last_ff;
   assign rsp_dropped_count = dropped_total_ff;
   assign rsp_error_count   = error_total_ff;

`include "magic_length_frame_deframer_core_assert.svh"

   `MLFD_ASSERT_IMPLY(a_last_only_frame, clock, reset, rsp_valid && rsp_frame_last, (rsp_status == ST_PAYLOAD) || (rsp_status == ST_EMPTY))
   `MLFD_ASSERT_IMPLY(a_skip_no_frame, clock, reset, skip_ff, header_count_ff == 4'd0)
   `MLFD_ASSERT_NEXT(a_skip_result, clock, reset, accept && skip_ff, rsp_valid && (rsp_status == ST_SKIP))
   `MLFD_ASSERT_IMPLY(a_error_step, clock, reset, !$past(reset) && !$stable(error_total_ff), rsp_valid && (rsp_status == ST_ERROR))

endmodule
